// ===== sv/swv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sliding-window varimax block.
// Used by the controller, the datapath and the top level; depends on nothing.
package swv_pkg;

   // Per-frame accumulator widths, sized for 12-bit samples and 4096-sample frames.
   localparam int SQ_W  = 35;
   localparam int Q4_W  = 57;
   localparam int CNT_W = 13;
   localparam int THR_W = 38;
   localparam int MEAS_W = 32;
   localparam int FNUM_W = 16;
   localparam int FRAC_W = 16;

   // Configuration register indexes.
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLIDING_MODE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_WIDTH   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD    = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;       // a sample item is accepted this cycle
      logic load;       // set up the window walk of the oldest pending frame
      logic sum;        // one step of the window walk
      logic thr;        // threshold test and multiplier setup
      logic mul;        // one step of the serial multipliers
      logic div_init;   // saturation test and divider setup
      logic div;        // one restoring division step
      logic push;       // move the result into the output register
      logic clear;      // end of stream: return stream state to reset
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_closed;
      logic any_ready;
      logic fin;
      logic sum_done;
      logic below_thr;
      logic mul_done;
      logic sat;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

// ===== sv/sliding_window_varimax.sv =====
`timescale 1ns / 1ps
// Top level of the sliding-window varimax block: ports, configuration
// registers, and the controller and datapath. Depends on swv_pkg, swv_ctrl, swv_dp.
//
// Samples are taken one item per cycle while a frame is open. The item that
// closes a frame (tlast high) stops input while the frame sums settle in a
// three-stage square and fourth-power pipeline and are written to the frame
// ring; the block then emits every result whose window is complete. Each
// result passes through the window walk over the ring memory (W frames in
// the window, one read a cycle), the serial shift-and-add multipliers that
// form count*sum4 and sum2^2, and the restoring divider, with
// control states between them; a result at or below the
// threshold or one that saturates skips the later phases. Input resumes after
// the last ready result has been moved to the output register, which can
// hold one result while the next item is accepted. The ring needs no clearing
// pass after reset: a fill count keeps never-written entries from being read.
// At stream end (tuser high with tlast) all pending frames are flushed, the
// final result carries tlast, and frame numbering restarts at zero.
module sliding_window_varimax #(
   parameter int MAX_HALF          = 7,
   parameter int MAX_FRAME_SAMPLES = 4096,
   parameter int SAMPLE_BITS       = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: sample (SAMPLE_BITS, signed), zero fill to whole bytes
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tlast,   // frame_end
   input  logic                                req_tuser,   // stream_end
   // rsp_tdata: measure [31:0], frame_number [47:32]
   output logic [47:0]                         rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tlast,   // last
   input  logic                                csr_we,
   input  logic [swv_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [swv_pkg::THR_W-1:0]           csr_wdata
);
   import swv_pkg::*;

   localparam int PW = $clog2(MAX_HALF + 2);

   logic              sliding_ff;
   logic [2:0]        half_width_ff;
   logic [THR_W-1:0]  threshold_ff;
   logic [PW-1:0]     half;
   cmd_type           cmd;
   sts_type           sts;
   logic [MEAS_W-1:0] measure;
   logic [FNUM_W-1:0] frame_number;

   // A write takes effect at once, so the registers are meant to be written
   // only while the block is idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         sliding_ff    <= 1'b0;
         half_width_ff <= '0;
         threshold_ff  <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SLIDING_MODE: sliding_ff    <= csr_wdata[0];
            CSR_HALF_WIDTH:   half_width_ff <= csr_wdata[2:0];
            CSR_THRESHOLD:    threshold_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Window radius in use: the register clamped to the ring, or zero when
   // each frame is taken alone.
   always_comb begin
      if (!sliding_ff) half = '0;
      else if (32'(half_width_ff) > MAX_HALF) half = PW'(MAX_HALF);
      else half = PW'(half_width_ff);
   end

   swv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   swv_dp #(
      .MAX_HALF          (MAX_HALF),
      .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
      .SAMPLE_BITS       (SAMPLE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .sample           (req_tdata[SAMPLE_BITS-1:0]),
      .frame_end        (req_tlast),
      .stream_end       (req_tuser),
      .half             (half),
      .threshold        (threshold_ff),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_measure      (measure),
      .rsp_frame_number (frame_number),
      .rsp_last         (rsp_tlast)
   );

   assign rsp_tdata = {frame_number, measure};

endmodule

// ===== sv/swv_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the sliding-window varimax block.
// Depends on swv_pkg for the command and status structs.
module swv_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tlast,
   output logic             req_tready,
   input  swv_pkg::sts_type sts,
   output swv_pkg::cmd_type cmd
);
   import swv_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_WAIT  = 9'b000000010,
      ST_CHECK = 9'b000000100,
      ST_SUM   = 9'b000001000,
      ST_THR   = 9'b000010000,
      ST_MUL   = 9'b000100000,
      ST_SAT   = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_PUSH  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
            if (req_tvalid && req_tlast) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.frame_closed) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.any_ready) begin
               cmd.load = 1'b1;
               state_in = ST_SUM;
            end else begin
               cmd.clear = sts.fin;
               state_in  = ST_IDLE;
            end
         end
         ST_SUM: begin
            if (sts.sum_done) state_in = ST_THR;
            else cmd.sum = 1'b1;
         end
         ST_THR: begin
            cmd.thr  = 1'b1;
            state_in = sts.below_thr ? ST_PUSH : ST_MUL;
         end
         ST_MUL: begin
            if (sts.mul_done) state_in = ST_SAT;
            else cmd.mul = 1'b1;
         end
         ST_SAT: begin
            cmd.div_init = 1'b1;
            state_in     = sts.sat ? ST_PUSH : ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_PUSH;
            else cmd.div = 1'b1;
         end
         ST_PUSH: begin
            if (sts.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== sv/swv_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the sliding-window varimax block: sample pipeline, frame ring,
// window walk, serial multipliers, restoring divider and output register.
// Depends on swv_pkg.
module swv_dp #(
   parameter int MAX_HALF          = 7,
   parameter int MAX_FRAME_SAMPLES = 4096,
   parameter int SAMPLE_BITS       = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [SAMPLE_BITS-1:0]     sample,
   input  logic                              frame_end,
   input  logic                              stream_end,
   input  logic [$clog2(MAX_HALF+2)-1:0]     half,
   input  logic [swv_pkg::THR_W-1:0]         threshold,
   input  swv_pkg::cmd_type                  cmd,
   output swv_pkg::sts_type                  sts,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [swv_pkg::MEAS_W-1:0]        rsp_measure,
   output logic [swv_pkg::FNUM_W-1:0]        rsp_frame_number,
   output logic                              rsp_last
);
   import swv_pkg::*;

   localparam int RING  = 2 * MAX_HALF + 1;
   localparam int AW    = (RING > 1) ? $clog2(RING) : 1;
   localparam int PW    = $clog2(MAX_HALF + 2);
   localparam int WB    = $clog2(RING + 1);
   localparam int WC    = CNT_W + WB;
   localparam int WS2   = SQ_W + WB;
   localparam int WS4   = Q4_W + WB;
   localparam int PRW   = WC + WS4;
   localparam int NW    = PRW + FRAC_W;
   localparam int DNW   = 2 * WS2;
   localparam int DSW   = DNW + MEAS_W - 1;
   localparam int CW    = (NW > DNW + MEAS_W) ? NW : DNW + MEAS_W;
   localparam int TW    = (WS2 > THR_W) ? WS2 : THR_W;
   localparam int FSAT  = 65535 + MAX_HALF + 1;
   localparam int FW    = $clog2(FSAT + 1);
   localparam int MCW   = $clog2(WS2 + 1);
   localparam int DCW   = $clog2(MEAS_W + 1);
   localparam int RW    = CNT_W + Q4_W + SQ_W;
   localparam int SB2   = 2 * SAMPLE_BITS;

   // Sample pipeline: square, then fourth power, then accumulate.
   logic              v1_ff, fe1_ff, se1_ff;
   logic [SB2-1:0]    sq1_ff;
   logic              v2_ff, fe2_ff, se2_ff;
   logic [SB2-1:0]    sq2_ff;
   logic [2*SB2-1:0]  q42_ff;
   logic signed [SB2-1:0] sq_prod;

   logic [SQ_W-1:0]   acc_sq_ff, acc_sq_in;
   logic [Q4_W-1:0]   acc_q4_ff, acc_q4_in;
   logic [CNT_W-1:0]  acc_cnt_ff, acc_cnt_in;
   logic              closing;

   // Stream state.
   logic [AW-1:0]     head_ff;
   logic [AW:0]       filled_ff;
   logic [FW-1:0]     frames_ff;
   logic [PW-1:0]     pending_ff;
   logic              fin_ff;
   logic              closed_ff;

   logic [RW-1:0]     ring_mem [RING];
   logic [RW-1:0]     rd_data_ff;
   logic              rdv_ff;

   // Window walk.
   logic [AW-1:0]     k_ff, kend_ff;
   logic              issue_ff;
   logic [WC-1:0]     sum_c_ff;
   logic [WS2-1:0]    sum_s2_ff;
   logic [WS4-1:0]    sum_s4_ff;
   logic [FNUM_W-1:0] fnum_ff;
   logic              last_ff;

   // Multipliers and divider.
   logic [WS2-1:0]    mb_ff, mc_ff;
   logic [DNW-1:0]    den_ff;
   logic [PRW-1:0]    prod_ff;
   logic [MCW-1:0]    mcnt_ff;
   logic [NW-1:0]     rem_ff;
   logic [DSW-1:0]    dsh_ff;
   logic [DCW-1:0]    dcnt_ff;
   logic [MEAS_W-1:0] q_ff;

   logic              out_valid_ff;
   logic [MEAS_W-1:0] out_meas_ff;
   logic [FNUM_W-1:0] out_fnum_ff;
   logic              out_last_ff;

   // Combinational helpers.
   logic [PW-1:0]     off;
   logic [AW:0]       first_w, lastoff_w, slot_w;
   logic [FW-1:0]     num_w;
   logic              rd_ge;

   assign sq_prod = sample * sample;
   assign closing = v2_ff && fe2_ff;

   always_comb begin
      acc_sq_in  = acc_sq_ff;
      acc_q4_in  = acc_q4_ff;
      acc_cnt_in = acc_cnt_ff;
      if (v2_ff && (acc_cnt_ff < CNT_W'(MAX_FRAME_SAMPLES))) begin
         acc_sq_in  = acc_sq_ff + SQ_W'(sq2_ff);
         acc_q4_in  = acc_q4_ff + Q4_W'(q42_ff);
         acc_cnt_in = acc_cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      off = pending_ff - PW'(1);
      first_w = (off >= half) ? (AW+1)'(off - half) : '0;
      lastoff_w = (AW+1)'(off) + (AW+1)'(half);
      if (lastoff_w >= filled_ff) lastoff_w = filled_ff - (AW+1)'(1);
      num_w = frames_ff - FW'(1) - FW'(off);
      slot_w = (AW+1)'(head_ff) + (AW+1)'(RING - 1) - (AW+1)'(k_ff);
      if (slot_w >= (AW+1)'(RING)) slot_w = slot_w - (AW+1)'(RING);
      rd_ge = CW'(rem_ff) >= CW'(dsh_ff);
   end

   always_comb begin
      sts.frame_closed = closed_ff;
      sts.any_ready    = (pending_ff != '0) && (fin_ff || (off >= half));
      sts.fin          = fin_ff;
      sts.sum_done     = !issue_ff && !rdv_ff;
      sts.below_thr    = TW'(sum_s2_ff) <= TW'(threshold);
      sts.mul_done     = mcnt_ff == MCW'(WS2);
      sts.sat          = CW'({prod_ff, {FRAC_W{1'b0}}}) >= CW'({den_ff, {MEAS_W{1'b0}}});
      sts.div_done     = dcnt_ff == DCW'(MEAS_W);
      sts.out_free     = !out_valid_ff || rsp_tready;
   end

   // Control state of the pipeline and the stream.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; closed_ff <= 1'b0;
         acc_sq_ff <= '0; acc_q4_ff <= '0; acc_cnt_ff <= '0;
         head_ff <= '0; filled_ff <= '0; frames_ff <= '0;
         pending_ff <= '0; fin_ff <= 1'b0;
         issue_ff <= 1'b0; rdv_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         v1_ff     <= cmd.take;
         v2_ff     <= v1_ff;
         closed_ff <= closing;
         if (closing) begin
            acc_sq_ff  <= '0;
            acc_q4_ff  <= '0;
            acc_cnt_ff <= '0;
            head_ff    <= (head_ff == AW'(RING - 1)) ? '0 : head_ff + AW'(1);
            if (filled_ff < (AW+1)'(RING)) filled_ff <= filled_ff + (AW+1)'(1);
            if (frames_ff < FW'(FSAT)) frames_ff <= frames_ff + FW'(1);
            pending_ff <= pending_ff + PW'(1);
            fin_ff     <= se2_ff;
         end else begin
            acc_sq_ff  <= acc_sq_in;
            acc_q4_ff  <= acc_q4_in;
            acc_cnt_ff <= acc_cnt_in;
         end
         if (cmd.clear) begin
            head_ff <= '0; filled_ff <= '0; frames_ff <= '0;
            pending_ff <= '0; fin_ff <= 1'b0;
         end
         if (cmd.push) pending_ff <= pending_ff - PW'(1);
         if (cmd.load) begin
            issue_ff <= 1'b1;
            rdv_ff   <= 1'b0;
         end else if (cmd.sum) begin
            rdv_ff <= issue_ff;
            if (issue_ff && (k_ff == kend_ff)) issue_ff <= 1'b0;
         end
         if (cmd.push) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sq1_ff <= SB2'($unsigned(sq_prod));
      fe1_ff <= frame_end;
      se1_ff <= stream_end;
      sq2_ff <= sq1_ff;
      q42_ff <= sq1_ff * sq1_ff;
      fe2_ff <= fe1_ff;
      se2_ff <= se1_ff;

      if (closing) ring_mem[head_ff] <= {acc_cnt_in, acc_q4_in, acc_sq_in};
      if (cmd.sum && issue_ff) rd_data_ff <= ring_mem[slot_w[AW-1:0]];

      if (cmd.load) begin
         k_ff      <= first_w[AW-1:0];
         kend_ff   <= lastoff_w[AW-1:0];
         sum_c_ff  <= '0;
         sum_s2_ff <= '0;
         sum_s4_ff <= '0;
         fnum_ff   <= (num_w > FW'(65535)) ? {FNUM_W{1'b1}} : num_w[FNUM_W-1:0];
         last_ff   <= fin_ff && (pending_ff == PW'(1));
      end
      if (cmd.sum) begin
         if (issue_ff && (k_ff != kend_ff)) k_ff <= k_ff + AW'(1);
         if (rdv_ff) begin
            sum_s2_ff <= sum_s2_ff + WS2'(rd_data_ff[SQ_W-1:0]);
            sum_s4_ff <= sum_s4_ff + WS4'(rd_data_ff[SQ_W+Q4_W-1:SQ_W]);
            sum_c_ff  <= sum_c_ff + WC'(rd_data_ff[RW-1:SQ_W+Q4_W]);
         end
      end

      if (cmd.thr) begin
         q_ff    <= '0;
         mb_ff   <= sum_s2_ff;
         mc_ff   <= WS2'(sum_c_ff);
         den_ff  <= '0;
         prod_ff <= '0;
         mcnt_ff <= '0;
      end
      // MSB-first shift-and-add: one multiplier bit per step.
      if (cmd.mul) begin
         den_ff  <= (den_ff << 1) + (mb_ff[WS2-1] ? DNW'(sum_s2_ff) : '0);
         prod_ff <= (prod_ff << 1) + (mc_ff[WS2-1] ? PRW'(sum_s4_ff) : '0);
         mb_ff   <= mb_ff << 1;
         mc_ff   <= mc_ff << 1;
         mcnt_ff <= mcnt_ff + MCW'(1);
      end
      if (cmd.div_init) begin
         q_ff    <= {MEAS_W{1'b1}};
         rem_ff  <= {prod_ff, {FRAC_W{1'b0}}};
         dsh_ff  <= {den_ff, {(MEAS_W-1){1'b0}}};
         dcnt_ff <= '0;
      end
      if (cmd.div) begin
         if (rd_ge) rem_ff <= rem_ff - NW'(dsh_ff);
         q_ff    <= {q_ff[MEAS_W-2:0], rd_ge};
         dsh_ff  <= dsh_ff >> 1;
         dcnt_ff <= dcnt_ff + DCW'(1);
      end

      if (cmd.push) begin
         out_meas_ff <= q_ff;
         out_fnum_ff <= fnum_ff;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid       = out_valid_ff;
   assign rsp_measure      = out_meas_ff;
   assign rsp_frame_number = out_fnum_ff;
   assign rsp_last         = out_last_ff;

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PW'(MAX_HALF + 1))
      else $error("pending frame count above window radius bound");

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= (AW+1)'(RING))
      else $error("ring fill count above ring depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!out_valid_ff || rsp_tready))
      else $error("result pushed over an untaken result");

   a_close_idle: assert property (@(posedge clock) disable iff (reset)
      closing |-> !issue_ff && !cmd.push)
      else $error("frame closed while a result is in progress");

endmodule
